### design/dxt1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared widths, colour types and constants for the BC1 block decoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

	localparam int unsigned BlockWidth = 64;
	localparam int unsigned PixelWidth = 32;
	localparam int unsigned IndexWidth = 32;

	// alpha byte forced on every decoded pixel
	localparam logic [7:0] OpaqueAlpha = 8'hFF;

	// x / 3 == (x * 683) >> 11 for every x below 2048
	localparam logic [9:0] Recip3      = 10'd683;
	localparam int unsigned Recip3Shift = 11;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgb_t;

	typedef struct packed {
		logic [9:0] b;
		logic [9:0] g;
		logic [9:0] r;
	} wsum_t;

endpackage
`default_nettype wire

### design/dxt1_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt1_in_if
// Valid/ready channel carrying one compressed 64-bit block per transaction.
// ----------------------------------------------------------------------------
interface dxt1_in_if
	import dxt1_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [BlockWidth-1:0] block_word;

	modport source (output valid, output block_word, input ready);
	modport sink   (input valid, input block_word, output ready);
endinterface
`default_nettype wire

### design/dxt1_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt1_out_if
// Valid/ready channel carrying one decoded row of four pixels per transaction.
// ----------------------------------------------------------------------------
interface dxt1_out_if
	import dxt1_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            row_number;
	logic [PixelWidth-1:0] pixel_col0;
	logic [PixelWidth-1:0] pixel_col1;
	logic [PixelWidth-1:0] pixel_col2;
	logic [PixelWidth-1:0] pixel_col3;
	logic                  last_row;

	modport source (output valid, output row_number, output pixel_col0, output pixel_col1,
		output pixel_col2, output pixel_col3, output last_row, input ready);
	modport sink   (input valid, input row_number, input pixel_col0, input pixel_col1,
		input pixel_col2, input pixel_col3, input last_row, output ready);
endinterface
`default_nettype wire

### design/dxt1_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt1_block_decoder
// BC1 (RGB) block decoder: one 64-bit block in, four rows of RGBA8888 out.
// ----------------------------------------------------------------------------
// Each accepted block passes three register stages (widen and compare, weighted
// sums, divide by three through a reciprocal multiply) and is then held in the
// output register, which sends one row of four pixels per transaction, rows 0
// to 3 in order, one row per cycle while the row side is ready; the next block
// loads into the output register as the last row of the current one is taken.
// The input keeps accepting while rows are still being delivered, up to three
// blocks in flight behind the output, and back-pressure from the row side
// stalls every stage without losing or repeating data.
module dxt1_block_decoder
	import dxt1_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	dxt1_in_if.sink     blocks,
	dxt1_out_if.source  rows
);

	function automatic rgb_t widen565(input logic [15:0] c);
		rgb_t w;
		w.r = {c[15:11], c[15:13]};
		w.g = {c[10:5], c[10:9]};
		w.b = {c[4:0], c[4:2]};
		return w;
	endfunction

	// 2*a + b per channel
	function automatic wsum_t wsum(input rgb_t a, input rgb_t b);
		wsum_t s;
		s.r = {1'b0, a.r, 1'b0} + {2'b00, b.r};
		s.g = {1'b0, a.g, 1'b0} + {2'b00, b.g};
		s.b = {1'b0, a.b, 1'b0} + {2'b00, b.b};
		return s;
	endfunction

	function automatic logic [7:0] mid8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] t);
		logic [19:0] p;
		p = t * Recip3;
		return p[Recip3Shift +: 8];
	endfunction

	function automatic rgb_t pick(input logic [1:0] code, input rgb_t p0, input rgb_t p1,
		input rgb_t p2, input rgb_t p3);
		rgb_t c;
		case (code)
			2'd0:    c = p0;
			2'd1:    c = p1;
			2'd2:    c = p2;
			default: c = p3;
		endcase
		return c;
	endfunction

	// stage 1: widened endpoints
	logic                  v_s1;
	rgb_t                  c0_s1, c1_s1;
	logic                  gt_s1;
	logic [IndexWidth-1:0] idx_s1;

	// stage 2: weighted sums and midpoint
	logic                  v_s2;
	rgb_t                  c0_s2, c1_s2, mid_s2;
	wsum_t                 t2_s2, t3_s2;
	logic                  gt_s2;
	logic [IndexWidth-1:0] idx_s2;

	// stage 3: thirds
	logic                  v_s3;
	rgb_t                  c0_s3, c1_s3, mid_s3, q2_s3, q3_s3;
	logic                  gt_s3;
	logic [IndexWidth-1:0] idx_s3;

	// output register: palette of the block being sent
	logic                  out_v_q;
	logic [1:0]            row_q;
	rgb_t                  pal0_q, pal1_q, pal2_q, pal3_q;
	logic [IndexWidth-1:0] idx_q;

	logic out_load, rdy3, rdy2, rdy1;

	assign out_load     = v_s3 && (!out_v_q || (rows.ready && row_q == 2'd3));
	assign rdy3         = !v_s3 || out_load;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign blocks.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= blocks.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (blocks.valid && rdy1) begin
			c0_s1  <= widen565(blocks.block_word[15:0]);
			c1_s1  <= widen565(blocks.block_word[31:16]);
			gt_s1  <= blocks.block_word[15:0] > blocks.block_word[31:16];
			idx_s1 <= blocks.block_word[63:32];
		end
		if (v_s1 && rdy2) begin
			c0_s2    <= c0_s1;
			c1_s2    <= c1_s1;
			t2_s2    <= wsum(c0_s1, c1_s1);
			t3_s2    <= wsum(c1_s1, c0_s1);
			mid_s2.r <= mid8(c0_s1.r, c1_s1.r);
			mid_s2.g <= mid8(c0_s1.g, c1_s1.g);
			mid_s2.b <= mid8(c0_s1.b, c1_s1.b);
			gt_s2    <= gt_s1;
			idx_s2   <= idx_s1;
		end
		if (v_s2 && rdy3) begin
			c0_s3   <= c0_s2;
			c1_s3   <= c1_s2;
			mid_s3  <= mid_s2;
			q2_s3.r <= div3(t2_s2.r);
			q2_s3.g <= div3(t2_s2.g);
			q2_s3.b <= div3(t2_s2.b);
			q3_s3.r <= div3(t3_s2.r);
			q3_s3.g <= div3(t3_s2.g);
			q3_s3.b <= div3(t3_s2.b);
			gt_s3   <= gt_s2;
			idx_s3  <= idx_s2;
		end
		if (out_load) begin
			pal0_q <= c0_s3;
			pal1_q <= c1_s3;
			pal2_q <= gt_s3 ? q2_s3 : mid_s3;
			pal3_q <= gt_s3 ? q3_s3 : '0;
			idx_q  <= idx_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			row_q   <= 2'd0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
			row_q   <= 2'd0;
		end else if (out_v_q && rows.ready) begin
			// drop the block after its last row, else advance
			if (row_q == 2'd3) out_v_q <= 1'b0;
			else row_q <= row_q + 2'd1;
		end
	end

	rgb_t px0, px1, px2, px3;

	always_comb begin
		px0 = pick(idx_q[{row_q, 3'd0} +: 2], pal0_q, pal1_q, pal2_q, pal3_q);
		px1 = pick(idx_q[{row_q, 3'd2} +: 2], pal0_q, pal1_q, pal2_q, pal3_q);
		px2 = pick(idx_q[{row_q, 3'd4} +: 2], pal0_q, pal1_q, pal2_q, pal3_q);
		px3 = pick(idx_q[{row_q, 3'd6} +: 2], pal0_q, pal1_q, pal2_q, pal3_q);
	end

	assign rows.valid      = out_v_q;
	assign rows.row_number = row_q;
	assign rows.last_row   = (row_q == 2'd3);
	assign rows.pixel_col0 = {OpaqueAlpha, px0};
	assign rows.pixel_col1 = {OpaqueAlpha, px1};
	assign rows.pixel_col2 = {OpaqueAlpha, px2};
	assign rows.pixel_col3 = {OpaqueAlpha, px3};

endmodule
`default_nettype wire

### design/dxt1_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt1_chk
// Port-level checks on the row sequence of the BC1 block decoder.
// ----------------------------------------------------------------------------
module dxt1_chk
	import dxt1_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [1:0]            row_number,
	input wire                  last_row,
	input wire [PixelWidth-1:0] pixel_col0
);

	// last_row marks row 3 and nothing else
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_number == 2'd3)))
		else $error("last_row does not match row_number");

	// rows of one block follow without a gap
	a_row_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_row) |=>
			(out_valid && row_number == $past(row_number) + 2'd1))
		else $error("row sequence broken inside a block");

	// a new block always starts at row 0
	a_row_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_row) |=> (!out_valid || row_number == 2'd0))
		else $error("block did not start at row 0");

	// hold a stalled row
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(row_number) && $stable(pixel_col0)))
		else $error("stalled row changed");

endmodule

bind dxt1_block_decoder dxt1_chk u_dxt1_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rows.valid),
	.out_ready  (rows.ready),
	.row_number (rows.row_number),
	.last_row   (rows.last_row),
	.pixel_col0 (rows.pixel_col0)
);
`default_nettype wire

### tb/tb_dxt1_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dxt1_block_decoder
// Self-checking bench for the BC1 block decoder. Blocks are fed through the
// input channel in bursts, each accepted block is decoded by a behavioural
// palette model into four expected rows, and every row delivered on the
// output channel (under a changing stall pattern) is checked field by field.
// ----------------------------------------------------------------------------
module tb_dxt1_block_decoder;
	import dxt1_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned RandomCount = 230;
	localparam int unsigned ShownErrors = 20;

	typedef struct {
		logic [1:0]                 row_number;
		logic [3:0][PixelWidth-1:0] pixels;
		logic                       last_row;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dxt1_in_if  blk_if ();
	dxt1_out_if row_if ();

	dxt1_block_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.blocks (blk_if),
		.rows   (row_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pixel_row_t  pending_rows[$];
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left  = 0;
	bit          steady_feed = 1'b0;

	// ---------------------------------------------------------------- palette

	function automatic rgb_t widen_565(input logic [15:0] c);
		rgb_t w;
		w.r = {c[15:11], c[15:13]};
		w.g = {c[10:5], c[10:9]};
		w.b = {c[4:0], c[4:2]};
		return w;
	endfunction

	function automatic rgb_t blend_rgb(input rgb_t a, input rgb_t b, input int wa, input int wb,
		input int div);
		rgb_t m;
		m.r = 8'((wa * int'(a.r) + wb * int'(b.r)) / div);
		m.g = 8'((wa * int'(a.g) + wb * int'(b.g)) / div);
		m.b = 8'((wa * int'(a.b) + wb * int'(b.b)) / div);
		return m;
	endfunction

	// Expand one block into its four rows and queue them.
	function automatic void decode_block_rows(input logic [BlockWidth-1:0] word);
		rgb_t                  w0;
		rgb_t                  w1;
		logic [PixelWidth-1:0] palette [4];
		logic [IndexWidth-1:0] idx;
		pixel_row_t            r;
		w0 = widen_565(word[15:0]);
		w1 = widen_565(word[31:16]);
		idx = word[63:32];
		palette[0] = {OpaqueAlpha, w0};
		palette[1] = {OpaqueAlpha, w1};
		if (word[15:0] > word[31:16]) begin
			palette[2] = {OpaqueAlpha, blend_rgb(w0, w1, 2, 1, 3)};
			palette[3] = {OpaqueAlpha, blend_rgb(w0, w1, 1, 2, 3)};
		end else begin
			// equal colours also take this branch
			palette[2] = {OpaqueAlpha, blend_rgb(w0, w1, 1, 1, 2)};
			palette[3] = {OpaqueAlpha, 24'h000000};
		end
		for (int row = 0; row < 4; row++) begin
			r.row_number = 2'(row);
			for (int col = 0; col < 4; col++)
				r.pixels[col] = palette[idx[2 * (4 * row + col) +: 2]];
			r.last_row = (row == 3);
			pending_rows.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= ShownErrors)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction, or later when a gap follows a burst.
	task automatic send_block(input logic [BlockWidth-1:0] word);
		blk_if.valid      <= 1'b1;
		blk_if.block_word <= word;
		do
			@(posedge clk);
		while (!blk_if.ready);
		decode_block_rows(word);
		@(negedge clk);
		if (!steady_feed) begin
			if (burst_left == 0) begin
				blk_if.valid      <= 1'b0;
				blk_if.block_word <= {$urandom, $urandom};
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		blk_if.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Receiver: rotate through always ready, coin toss, sparse and long stalls.
	always @(negedge clk) begin : row_stall
		int unsigned phase;
		phase = (cycle_count / 97) % 4;
		case (phase)
			0: row_if.ready <= 1'b1;
			1: row_if.ready <= 1'($urandom_range(0, 1));
			2: row_if.ready <= (cycle_count % 4 == 1);
			default: row_if.ready <= ((cycle_count % 23) < 12) ? 1'b0 : 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : check_rows
		pixel_row_t                 want;
		logic [3:0][PixelWidth-1:0] got;
		if (arst_n && row_if.valid && row_if.ready) begin
			got = {row_if.pixel_col3, row_if.pixel_col2, row_if.pixel_col1, row_if.pixel_col0};
			if (pending_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected row %0d", row_if.row_number));
			end else begin
				want = pending_rows.pop_front();
				if (row_if.row_number !== want.row_number)
					report_mismatch($sformatf("row_number got %0d want %0d",
						row_if.row_number, want.row_number));
				for (int col = 0; col < 4; col++)
					if (got[col] !== want.pixels[col])
						report_mismatch($sformatf("row %0d pixel_col%0d got %08h want %08h",
							want.row_number, col, got[col], want.pixels[col]));
				if (row_if.last_row !== want.last_row)
					report_mismatch($sformatf("row %0d last_row got %b want %b",
						want.row_number, row_if.last_row, want.last_row));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_colour_extremes();
		steady_feed = 1'b1;
		send_block(64'h0000_0000_0000_0000);
		send_block(64'hFFFF_FFFF_FFFF_FFFF);
		send_block(64'hE4E4_E4E4_0000_FFFF);
		send_block(64'hE4E4_E4E4_FFFF_0000);
		send_block(64'h1B1B_1B1B_0000_0001);
		send_block(64'h1B1B_1B1B_0001_0000);
		send_block(64'hE4E4_E4E4_FFFE_FFFF);
		send_block(64'hE4E4_E4E4_07E0_F800);
		send_block(64'hE4E4_E4E4_001F_07E0);
		send_block(64'hE4E4_E4E4_F800_001F);
	endtask

	task automatic test_index_patterns();
		steady_feed = 1'b0;
		burst_left = 1;
		// each index value across the whole block, four-colour and three-colour
		send_block(64'h0000_0000_2104_F7BE);
		send_block(64'h5555_5555_2104_F7BE);
		send_block(64'hAAAA_AAAA_2104_F7BE);
		send_block(64'hFFFF_FFFF_2104_F7BE);
		send_block(64'h0000_0000_F7BE_2104);
		send_block(64'h5555_5555_F7BE_2104);
		send_block(64'hAAAA_AAAA_F7BE_2104);
		send_block(64'hFFFF_FFFF_F7BE_2104);
	endtask

	task automatic test_equal_colours();
		send_block(64'hE4E4_E4E4_8410_8410);
		send_block(64'h1B6C_93D2_FFFF_FFFF);
		send_block(64'hAAAA_AAAA_0000_0000);
		wait_drained();
	endtask

	function automatic logic [15:0] pick_colour();
		logic [15:0] c;
		c = 16'($urandom);
		// now and then push channels to their limits
		if ($urandom_range(0, 4) == 0) begin
			c[15:11] = $urandom_range(0, 1) ? 5'h1F : 5'h00;
			c[10:5]  = $urandom_range(0, 1) ? 6'h3F : 6'h00;
			c[4:0]   = $urandom_range(0, 1) ? 5'h1F : 5'h00;
		end
		return c;
	endfunction

	task automatic test_random_blocks();
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] tmp;
		int unsigned kind;
		for (int n = 0; n < RandomCount; n++) begin
			// alternate stretches of back-to-back feeding with bursty feeding
			steady_feed = ((n / 40) % 3 == 1);
			c0 = pick_colour();
			c1 = pick_colour();
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				if (c0 < c1) begin
					tmp = c0;
					c0 = c1;
					c1 = tmp;
				end
				if (c0 == c1)
					c0 = ~c1;
			end else if (kind < 7) begin
				if (c0 > c1) begin
					tmp = c0;
					c0 = c1;
					c1 = tmp;
				end
			end else if (kind < 8) begin
				c1 = c0;
			end
			if (kind < 9)
				send_block({32'($urandom), c1, c0});
			else
				send_block({$urandom, $urandom});
		end
		wait_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		blk_if.valid      = 1'b0;
		blk_if.block_word = '0;
		row_if.ready      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_colour_extremes();
		test_index_patterns();
		test_equal_colours();
		test_random_blocks();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
